FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the frame timer RTL.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FTTU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTTU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fttu_pkg.sv
// Package for the frame timer: sequencer state type, register codes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package fttu_pkg;

  // Canonical tick rate.
  localparam int unsigned TICKS_PER_SECOND = 10000000;

  // Snap window around the target period, in canonical ticks.
  localparam logic [63:0] SNAP_WINDOW = 64'(TICKS_PER_SECOND / 4000);

  // Register reset values.
  localparam logic [31:0] TARGET_RESET    = 32'(TICKS_PER_SECOND / 60);
  localparam logic [31:0] FREQ_RESET      = 32'd10000000;
  localparam logic [31:0] MAX_DELTA_RESET = 32'd1000000;

  // Shared divider: one quotient bit per cycle over a 64-bit dividend.
  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 8'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_MUL,
    S_DIV,
    S_SNAP,
    S_ADD,
    S_EMIT,
    S_RATE,
    S_MOD
  } fttu_state_t;

endpackage

FILE: rtl/core/fttu_if.sv
// Channel interfaces of the frame timer: tick input, frame output, register write.
// Depends on fttu_pkg for the register index width.
`timescale 1ns / 1ps

interface fttu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] counter_now;

  modport source (output valid, kind, counter_now, input ready);
  modport sink   (input valid, kind, counter_now, output ready);
endinterface

interface fttu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] elapsed_ticks;
  logic [63:0] total_ticks;
  logic [31:0] frame_number;
  logic [31:0] frames_per_second;
  logic        last;

  modport source (output valid, elapsed_ticks, total_ticks, frame_number,
                  frames_per_second, last, input ready);
  modport sink   (input valid, elapsed_ticks, total_ticks, frame_number,
                  frames_per_second, last, output ready);
endinterface

interface fttu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fttu_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/fixed_timestep_frame_timer_unit.sv
// Frame pacing timer, top level. Depends on fttu_pkg, fttu_if.sv and assert_macros.svh.
// Channels: in_ch takes tick beats (kind 0, raw counter sample) and reset beats (kind 1);
// out_ch gives one beat per frame, last set on the final frame of a tick; cfg_ch writes
// fixed_mode (0), target_ticks (1), counter_frequency (2), max_delta (3); always ready.
// A tick walks a small sequencer around one shared restoring divider: clamp, a 32x32
// multiply by the tick rate, the divide for the tick conversion, snap, leftover add,
// then frames at one per cycle while out_ch keeps up. After the frames the rate check
// runs; when a counter second has filled, the same divider reduces the accumulator to
// its remainder. A reset beat keeps the sequencer idle and emits nothing.
// Reset (rst_n low at a clock edge) loads register defaults, clears all timing state and
// drops any pending frame. A stalled receiver holds the frame register; the sequencer
// waits in the frame loop and in_ch stays low until the tick is done.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_timestep_frame_timer_unit #(
  parameter int MAX_FRAMES_PER_TICK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  fttu_in_if.sink     in_ch,
  fttu_out_if.source  out_ch,
  fttu_cfg_if.sink    cfg_ch
);

  localparam int NW = $clog2(MAX_FRAMES_PER_TICK + 1);
  localparam int SW = fttu_pkg::STEP_W;

  // Configuration registers.
  logic        fixed_mode_r;
  logic [31:0] target_r;
  logic [31:0] freq_r;
  logic [31:0] max_delta_r;

  // Timing state.
  fttu_pkg::fttu_state_t state_r, state_nxt;
  logic [63:0] last_sample_r, last_sample_nxt;
  logic [63:0] sec_acc_r,     sec_acc_nxt;
  logic [63:0] tick_total_r,  tick_total_nxt;
  logic [63:0] leftover_r,    leftover_nxt;
  logic [31:0] frame_cnt_r,   frame_cnt_nxt;
  logic [31:0] rate_r,        rate_nxt;
  logic [31:0] fis_r,         fis_nxt;

  // Working registers of the sequencer and shared divider.
  logic [63:0]   delta_r, delta_nxt;
  logic [31:0]   clamp_r, clamp_nxt;
  logic [63:0]   dvd_r,   dvd_nxt;
  logic [31:0]   rem_r,   rem_nxt;
  logic [SW-1:0] step_r,  step_nxt;
  logic [NW-1:0] n_r,     n_nxt;

  // Frame output register.
  logic        out_valid_r,   out_valid_nxt;
  logic [63:0] out_elapsed_r, out_elapsed_nxt;
  logic [63:0] out_total_r,   out_total_nxt;
  logic [31:0] out_frame_r,   out_frame_nxt;
  logic [31:0] out_fps_r,     out_fps_nxt;
  logic        out_last_r,    out_last_nxt;

  // Combinational helpers.
  logic        in_fire;
  logic        out_free;
  logic [31:0] freq_eff;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [31:0] rem_step;
  logic        div_done;
  logic        can_frame;
  logic        frame_last;
  logic        emit_load;
  logic        emit_last;
  logic [63:0] tgt64;
  logic [63:0] diff;
  logic [64:0] sum_wide;
  logic        acc_ge;
  logic [31:0] fis_inc;

  assign in_ch.ready  = (state_r == fttu_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.elapsed_ticks     = out_elapsed_r;
  assign out_ch.total_ticks       = out_total_r;
  assign out_ch.frame_number      = out_frame_r;
  assign out_ch.frames_per_second = out_fps_r;
  assign out_ch.last              = out_last_r;

  // A zero frequency counts as one.
  assign freq_eff = (freq_r == 32'd0) ? 32'd1 : freq_r;
  assign tgt64    = {32'd0, target_r};

  // One restoring divide step: shift in the next dividend bit, subtract when it fits.
  assign rem_sh   = {rem_r, dvd_r[63]};
  assign div_ge   = rem_sh >= {1'b0, freq_eff};
  assign rem_step = div_ge ? 32'(rem_sh - {1'b0, freq_eff}) : rem_sh[31:0];
  assign div_done = (step_r == SW'(fttu_pkg::DIV_STEPS - 1));

  // Frame loop: a whole period fits under the cap; last at the cap or if no second fits.
  assign can_frame  = (n_r < NW'(MAX_FRAMES_PER_TICK)) && (leftover_r >= tgt64);
  assign frame_last = (n_r == NW'(MAX_FRAMES_PER_TICK - 1)) ||
                      ({1'b0, leftover_r} < {32'd0, target_r, 1'b0});
  assign emit_load  = (state_r == fttu_pkg::S_EMIT) && out_free &&
                      (!fixed_mode_r || can_frame);
  assign emit_last  = !fixed_mode_r || frame_last;

  assign diff     = (dvd_r >= tgt64) ? (dvd_r - tgt64) : (tgt64 - dvd_r);
  assign sum_wide = {1'b0, leftover_r} + {1'b0, dvd_r};
  assign acc_ge   = sec_acc_r >= {32'd0, freq_eff};
  assign fis_inc  = fis_r + 32'((n_r != '0) ? 1 : 0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fttu_pkg::S_IDLE: begin
        if (in_fire && !in_ch.kind) state_nxt = fttu_pkg::S_CLAMP;
      end
      fttu_pkg::S_CLAMP: state_nxt = fttu_pkg::S_MUL;
      fttu_pkg::S_MUL:   state_nxt = fttu_pkg::S_DIV;
      fttu_pkg::S_DIV: begin
        if (div_done) state_nxt = fttu_pkg::S_SNAP;
      end
      fttu_pkg::S_SNAP:  state_nxt = fttu_pkg::S_ADD;
      fttu_pkg::S_ADD:   state_nxt = fttu_pkg::S_EMIT;
      fttu_pkg::S_EMIT: begin
        // Leave once the final frame is loaded, or when no frame fits at all.
        priority if (!out_free) state_nxt = fttu_pkg::S_EMIT;
        else if (emit_load && !emit_last) state_nxt = fttu_pkg::S_EMIT;
        else state_nxt = fttu_pkg::S_RATE;
      end
      fttu_pkg::S_RATE: begin
        state_nxt = acc_ge ? fttu_pkg::S_MOD : fttu_pkg::S_IDLE;
      end
      fttu_pkg::S_MOD: begin
        if (div_done) state_nxt = fttu_pkg::S_IDLE;
      end
      default: state_nxt = fttu_pkg::S_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    last_sample_nxt = last_sample_r;
    sec_acc_nxt     = sec_acc_r;
    tick_total_nxt  = tick_total_r;
    leftover_nxt    = leftover_r;
    frame_cnt_nxt   = frame_cnt_r;
    rate_nxt        = rate_r;
    fis_nxt         = fis_r;
    delta_nxt       = delta_r;
    clamp_nxt       = clamp_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    n_nxt           = n_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_elapsed_nxt = out_elapsed_r;
    out_total_nxt   = out_total_r;
    out_frame_nxt   = out_frame_r;
    out_fps_nxt     = out_fps_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      fttu_pkg::S_IDLE: begin
        if (in_fire) begin
          last_sample_nxt = in_ch.counter_now;
          if (in_ch.kind) begin
            // Reset beat: recapture the sample, drop leftover and rate tracking.
            leftover_nxt = '0;
            rate_nxt     = '0;
            fis_nxt      = '0;
            sec_acc_nxt  = '0;
          end else begin
            delta_nxt = in_ch.counter_now - last_sample_r;
            n_nxt     = '0;
          end
        end
      end
      fttu_pkg::S_CLAMP: begin
        sec_acc_nxt = sec_acc_r + delta_r;
        clamp_nxt   = (delta_r > {32'd0, max_delta_r}) ? max_delta_r : delta_r[31:0];
      end
      fttu_pkg::S_MUL: begin
        dvd_nxt  = 64'(clamp_r) * 64'(fttu_pkg::TICKS_PER_SECOND);
        rem_nxt  = '0;
        step_nxt = '0;
      end
      fttu_pkg::S_DIV, fttu_pkg::S_MOD: begin
        dvd_nxt  = {dvd_r[62:0], div_ge};
        rem_nxt  = rem_step;
        step_nxt = step_r + SW'(1);
        if (state_r == fttu_pkg::S_MOD && div_done) sec_acc_nxt = {32'd0, rem_step};
      end
      fttu_pkg::S_SNAP: begin
        if (fixed_mode_r && diff < fttu_pkg::SNAP_WINDOW) dvd_nxt = tgt64;
      end
      fttu_pkg::S_ADD: begin
        // Saturate the leftover; variable mode keeps none.
        if (fixed_mode_r) leftover_nxt = sum_wide[64] ? '1 : sum_wide[63:0];
        else              leftover_nxt = '0;
      end
      fttu_pkg::S_EMIT: begin
        if (emit_load) begin
          out_valid_nxt   = 1'b1;
          out_elapsed_nxt = fixed_mode_r ? tgt64 : dvd_r;
          out_total_nxt   = tick_total_r + (fixed_mode_r ? tgt64 : dvd_r);
          out_frame_nxt   = frame_cnt_r + 32'd1;
          out_fps_nxt     = rate_r;
          out_last_nxt    = emit_last;
          tick_total_nxt  = tick_total_r + (fixed_mode_r ? tgt64 : dvd_r);
          frame_cnt_nxt   = frame_cnt_r + 32'd1;
          n_nxt           = n_r + NW'(1);
          if (fixed_mode_r) leftover_nxt = leftover_r - tgt64;
        end
      end
      fttu_pkg::S_RATE: begin
        if (acc_ge) begin
          // A counter second has filled: latch the rate, reduce the accumulator.
          rate_nxt = fis_inc;
          fis_nxt  = '0;
          dvd_nxt  = sec_acc_r;
          rem_nxt  = '0;
          step_nxt = '0;
        end else begin
          fis_nxt = fis_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_mode_r <= 1'b0;
      target_r     <= fttu_pkg::TARGET_RESET;
      freq_r       <= fttu_pkg::FREQ_RESET;
      max_delta_r  <= fttu_pkg::MAX_DELTA_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        fttu_pkg::CFG_FIXED_MODE: fixed_mode_r <= cfg_ch.data[0];
        fttu_pkg::CFG_TARGET:     target_r     <= cfg_ch.data;
        fttu_pkg::CFG_FREQ:       freq_r       <= cfg_ch.data;
        fttu_pkg::CFG_MAX_DELTA:  max_delta_r  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fttu_pkg::S_IDLE;
      last_sample_r <= '0;
      sec_acc_r     <= '0;
      tick_total_r  <= '0;
      leftover_r    <= '0;
      frame_cnt_r   <= '0;
      rate_r        <= '0;
      fis_r         <= '0;
      step_r        <= '0;
      n_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_sample_r <= last_sample_nxt;
      sec_acc_r     <= sec_acc_nxt;
      tick_total_r  <= tick_total_nxt;
      leftover_r    <= leftover_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      rate_r        <= rate_nxt;
      fis_r         <= fis_nxt;
      step_r        <= step_nxt;
      n_r           <= n_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    delta_r       <= delta_nxt;
    clamp_r       <= clamp_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    out_total_r   <= out_total_nxt;
    out_frame_r   <= out_frame_nxt;
    out_fps_r     <= out_fps_nxt;
    out_last_r    <= out_last_nxt;
  end

  `FTTU_ASSERT_NXT(a_tick_busy, clk, rst_n, in_fire && !in_ch.kind, !in_ch.ready,
                   "tick beat did not make the block busy")
  `FTTU_ASSERT_NXT(a_last_ends_loop, clk, rst_n, emit_load && emit_last,
                   state_r == fttu_pkg::S_RATE, "frame loop ran past the last frame")
  `FTTU_ASSERT_NXT(a_mod_reduced, clk, rst_n, state_r == fttu_pkg::S_MOD && div_done,
                   sec_acc_r < {32'd0, freq_eff}, "second accumulator not reduced")
  `FTTU_ASSERT_IMP(a_frame_cap, clk, rst_n, 1'b1, n_r <= NW'(MAX_FRAMES_PER_TICK),
                   "frame count passed the per-tick cap")

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for the frame pacing timer: directed table, then random phases.
// Depends on fttu_pkg and the channel interfaces in fttu_if.sv; predicts every frame beat.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_FRAMES    = 64;
  localparam int PHASE_BEATS   = 20;
  // Long run of mostly full-size ticks: the leftover climbs far and every tick hits the cap.
  localparam int FLOOD_BEATS   = 300;
  // Covers a full tick, a frame burst and the rate divide after the last frame.
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 3000000;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  localparam logic [63:0] SEED_SAMPLE = 64'hA5A5_5A5A_0F0F_F0EB;

  typedef struct packed {
    logic [63:0] elapsed;
    logic [63:0] total;
    logic [31:0] number;
    logic [31:0] fps;
    logic        last;
  } frame_t;

  typedef enum {ROW_BEAT, ROW_REGS} plan_op_t;

  typedef struct {
    plan_op_t    op;
    logic        kind;
    logic [63:0] sample;
    bit          typed;
    frame_t      want;
    logic        r_mode;
    logic [31:0] r_period;
    logic [31:0] r_freq;
    logic [31:0] r_cap;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  fttu_in_if  in_ch ();
  fttu_out_if out_ch ();
  fttu_cfg_if cfg_ch ();

  fixed_timestep_frame_timer_unit #(
    .MAX_FRAMES_PER_TICK(MAX_FRAMES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow of the register file, as last programmed.
  logic        mode_fixed;
  logic [31:0] period_ticks;
  logic [31:0] cnt_freq;
  logic [31:0] delta_cap;

  // Shadow of the timing state.
  logic [63:0] prev_sample;
  logic [63:0] raw_in_second;
  logic [63:0] run_total;
  logic [63:0] carry_ticks;
  logic [31:0] frame_cnt;
  logic [31:0] fps_latched;
  logic [31:0] frames_this_sec;

  frame_t      step_frames[$];   // frames caused by the beat just accepted
  frame_t      frames_due[$];    // frames still owed by the block, oldest first
  plan_row_t   plan[$];

  int          mismatches  = 0;
  int          burst_left  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  logic [7:0]  stall_bits;

  // ---------------------------------------------------------------------------
  // Frame timing predictor. Computes the frames a beat causes into step_frames
  // and advances the shadow state exactly as the block should.
  // ---------------------------------------------------------------------------
  function automatic void step_timer(input logic kind, input logic [63:0] now);
    logic [63:0] freq;
    logic [63:0] dlt;
    logic [63:0] ticks;
    logic [63:0] tgt;
    logic [63:0] diff;
    logic [31:0] fps_before;
    int          n;
    // A zero frequency behaves as one, for conversion and for the second latch.
    freq       = (cnt_freq == 32'd0) ? 64'd1 : {32'd0, cnt_freq};
    fps_before = fps_latched;
    n          = 0;
    step_frames.delete();
    if (kind == KIND_RESET) begin
      // Recapture the sample, drop the leftover and the rate tracking, emit nothing.
      prev_sample     = now;
      carry_ticks     = '0;
      fps_latched     = '0;
      frames_this_sec = '0;
      raw_in_second   = '0;
      return;
    end
    // The raw delta wraps when the counter runs backward; the unclamped delta
    // feeds the one-second accumulator.
    dlt           = now - prev_sample;
    prev_sample   = now;
    raw_in_second = raw_in_second + dlt;
    if (dlt > {32'd0, delta_cap}) dlt = {32'd0, delta_cap};
    ticks = dlt * 64'(fttu_pkg::TICKS_PER_SECOND) / freq;
    if (mode_fixed) begin
      tgt  = {32'd0, period_ticks};
      diff = (ticks >= tgt) ? ticks - tgt : tgt - ticks;
      if (diff < fttu_pkg::SNAP_WINDOW) ticks = tgt;
      // Saturate the leftover instead of wrapping.
      if (carry_ticks > ~64'd0 - ticks) carry_ticks = ~64'd0;
      else carry_ticks = carry_ticks + ticks;
      // One frame per whole period, capped; the rest stays for later ticks.
      while (n < MAX_FRAMES && carry_ticks >= tgt) begin
        run_total   = run_total + tgt;
        carry_ticks = carry_ticks - tgt;
        frame_cnt   = frame_cnt + 32'd1;
        step_frames.push_back('{tgt, run_total, frame_cnt, fps_before, 1'b0});
        n++;
      end
    end else begin
      run_total   = run_total + ticks;
      carry_ticks = '0;
      frame_cnt   = frame_cnt + 32'd1;
      step_frames.push_back('{ticks, run_total, frame_cnt, fps_before, 1'b0});
      n = 1;
    end
    if (n > 0) begin
      step_frames[n-1].last = 1'b1;
      frames_this_sec       = frames_this_sec + 32'd1;
    end
    // Latch the rate once a full counter second has gone by.
    if (raw_in_second >= freq) begin
      fps_latched     = frames_this_sec;
      frames_this_sec = '0;
      raw_in_second   = raw_in_second % freq;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t ns: frame mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. The sender works in bursts: after each burst it may hold valid
  // low for a random gap. A beat is taken at an edge where valid and ready are
  // both high; the prediction is queued in that same step, well before any
  // frame of it can appear.
  // ---------------------------------------------------------------------------
  task automatic issue_beat(input logic kind, input logic [63:0] sample, input bit typed,
                            input frame_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // A third of the bursts follow the previous one with no gap at all.
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.counter_now <= sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    step_timer(kind, sample);
    // Rows with a hand-written expectation override the predictor's frame.
    if (typed) frames_due.push_back(want);
    else foreach (step_frames[i]) frames_due.push_back(step_frames[i]);
  endtask

  // Hold the input quiet, wait for every owed frame, then let the block finish
  // any tick that emits nothing and the trailing rate divide.
  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; valid stays high across the beats.
  task automatic program_regs(input logic mode, input logic [31:0] period,
                              input logic [31:0] freq, input logic [31:0] cap);
    logic [fttu_pkg::CFG_IDX_W-1:0] idx[4];
    logic [31:0]                    val[4];
    idx = '{fttu_pkg::CFG_FIXED_MODE, fttu_pkg::CFG_TARGET, fttu_pkg::CFG_FREQ,
            fttu_pkg::CFG_MAX_DELTA};
    val = '{{31'd0, mode}, period, freq, cap};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    mode_fixed   = mode;
    period_ticks = period;
    cnt_freq     = freq;
    delta_cap    = cap;
  endtask

  // ---------------------------------------------------------------------------
  // Random ticks shaped to the current settings. Most ticks land near one
  // target period so the snap window is hit from both sides; the rest are
  // clamped, backward, zero and full-range deltas, plus reset beats. In flood
  // mode nearly every tick carries a full-size delta and no reset is sent, so
  // the leftover climbs high and every tick runs into the frame cap.
  // ---------------------------------------------------------------------------
  task automatic random_beats(input int count, input bit flood);
    logic        kind;
    logic [63:0] sample;
    logic [63:0] step;
    logic [63:0] freq_eff;
    logic [63:0] raw_period;
    logic [63:0] jit_span;
    logic [63:0] off;
    int          pick;
    freq_eff   = (cnt_freq == 32'd0) ? 64'd1 : {32'd0, cnt_freq};
    raw_period = {32'd0, period_ticks} * freq_eff / 64'(fttu_pkg::TICKS_PER_SECOND);
    // Twice the snap window in raw counts, so jitter straddles its edge.
    jit_span   = fttu_pkg::SNAP_WINDOW * freq_eff / 64'(fttu_pkg::TICKS_PER_SECOND) * 2
                 + 64'd2;
    if (jit_span > 64'd1000000) jit_span = 64'd1000000;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      kind = KIND_TICK;
      step = '0;
      sample = '0;
      if (flood && pick >= 2) begin
        step = {32'($urandom) | 32'h1, 32'($urandom)};
      end else if (!flood && pick < 6) begin
        kind   = KIND_RESET;
        sample = {32'($urandom), 32'($urandom)};
      end else if (pick < 56) begin
        off  = 64'($urandom_range(0, 32'(jit_span)));
        step = raw_period + off;
        step = (step > jit_span / 2) ? step - jit_span / 2 : 64'd0;
      end else if (pick < 78) begin
        step = 64'($urandom_range(0, delta_cap));
      end else if (pick < 90) begin
        step = {32'($urandom), 32'($urandom)};
      end else if (pick < 95) begin
        step = -64'($urandom_range(1, 5000));
      end
      if (kind == KIND_TICK) sample = prev_sample + step;
      issue_beat(kind, sample, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. A beat row with a typed frame is one whose single frame is
  // plain to see; all other rows are checked against the predictor.
  // ---------------------------------------------------------------------------
  function automatic void plan_beat(input logic kind, input logic [63:0] sample,
                                    input bit typed, input logic [63:0] el,
                                    input logic [63:0] tot, input logic [31:0] num,
                                    input logic [31:0] fps);
    plan_row_t r;
    r        = '{op: ROW_BEAT, default: '0};
    r.kind   = kind;
    r.sample = sample;
    r.typed  = typed;
    r.want   = '{el, tot, num, fps, 1'b1};
    plan.push_back(r);
  endfunction

  function automatic void plan_regs(input logic mode, input logic [31:0] period,
                                    input logic [31:0] freq, input logic [31:0] cap);
    plan_row_t r;
    r          = '{op: ROW_REGS, default: '0};
    r.r_mode   = mode;
    r.r_period = period;
    r.r_freq   = freq;
    r.r_cap    = cap;
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: the receiver stalls on a rotating 8-bit pattern that is
  // reloaded when its random run count runs out, sometimes all ones for stall-free runs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_bits = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_bits = {stall_bits[0], stall_bits[7:1]};
      stall_left--;
    end
    out_ch.ready <= stall_bits[0];
  end

  // Compare each accepted frame beat, field by field, with the oldest owed frame.
  always @(posedge clk) begin
    frame_t owed;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch("frame_number (no frame owed)", 64'(out_ch.frame_number), 64'd0);
      end else begin
        owed = frames_due.pop_front();
        if (out_ch.elapsed_ticks !== owed.elapsed)
          report_mismatch("elapsed_ticks", out_ch.elapsed_ticks, owed.elapsed);
        if (out_ch.total_ticks !== owed.total)
          report_mismatch("total_ticks", out_ch.total_ticks, owed.total);
        if (out_ch.frame_number !== owed.number)
          report_mismatch("frame_number", 64'(out_ch.frame_number), 64'(owed.number));
        if (out_ch.frames_per_second !== owed.fps)
          report_mismatch("frames_per_second", 64'(out_ch.frames_per_second),
                          64'(owed.fps));
        if (out_ch.last !== owed.last)
          report_mismatch("last", 64'(out_ch.last), 64'(owed.last));
      end
    end
  end

  // Hard stop for a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_TICK;
    in_ch.counter_now <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= fttu_pkg::CFG_FIXED_MODE;
    cfg_ch.data       <= '0;

    // Power-on settings and a cleared timing state.
    mode_fixed      = 1'b0;
    period_ticks    = fttu_pkg::TARGET_RESET;
    cnt_freq        = fttu_pkg::FREQ_RESET;
    delta_cap       = fttu_pkg::MAX_DELTA_RESET;
    prev_sample     = '0;
    raw_in_second   = '0;
    run_total       = '0;
    carry_ticks     = '0;
    frame_cnt       = '0;
    fps_latched     = '0;
    frames_this_sec = '0;

    // Default settings: the first delta runs from a sample of zero; then a
    // zero delta, a huge delta that clamps and fills a counter second, and a
    // wrap from all ones back to zero that shows the latched rate.
    plan_beat(KIND_TICK, 64'd100, 1'b1, 64'd100, 64'd100, 32'd1, 32'd0);
    plan_beat(KIND_TICK, 64'd100, 1'b1, 64'd0, 64'd100, 32'd2, 32'd0);
    plan_beat(KIND_TICK, ~64'd0, 1'b1, 64'd1000000, 64'd1000100, 32'd3, 32'd0);
    plan_beat(KIND_TICK, 64'd0, 1'b1, 64'd1, 64'd1000101, 32'd4, 32'd3);
    // Reset beat emits nothing; the counter then steps backward and clamps.
    plan_beat(KIND_RESET, SEED_SAMPLE + 64'd5, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_TICK, SEED_SAMPLE, 1'b1, 64'd1000000, 64'd2000101, 32'd5, 32'd0);
    // Fixed timestep at the default period: exact hit, partial period with no
    // frame, a snapped near miss, then several periods in one tick.
    plan_regs(1'b1, fttu_pkg::TARGET_RESET, fttu_pkg::FREQ_RESET,
              fttu_pkg::MAX_DELTA_RESET);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd166666, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd266666, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd434666, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd1434666, 1'b0, '0, '0, '0, '0);
    // Short period with no clamp: the frame cap is hit and the rest is carried.
    plan_regs(1'b1, 32'd1000, fttu_pkg::FREQ_RESET, 32'hFFFF_FFFF);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd6434666, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd6434666, 1'b0, '0, '0, '0, '0);
    // Zero period and zero frequency: capped bursts of empty frames.
    plan_regs(1'b1, 32'd0, 32'd0, 32'd1000);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd6434676, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd6434676, 1'b0, '0, '0, '0, '0);
    // Variable timestep with a zero clamp, then full-range frequency extremes.
    plan_regs(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    plan_beat(KIND_TICK, SEED_SAMPLE + 64'd6447021, 1'b0, '0, '0, '0, '0);
    plan_beat(KIND_RESET, 64'd0, 1'b0, '0, '0, '0, '0);
    plan_regs(1'b0, 32'd1, 32'd0, 32'hFFFF_FFFF);
    plan_beat(KIND_TICK, 64'h0000_0000_FFFF_FFFF, 1'b0, '0, '0, '0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].op == ROW_REGS) begin
        drain_frames();
        program_regs(plan[i].r_mode, plan[i].r_period, plan[i].r_freq, plan[i].r_cap);
      end else begin
        issue_beat(plan[i].kind, plan[i].sample, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own settings; the last one floods the leftover.
    for (int ph = 0; ph < 9; ph++) begin
      drain_frames();
      case (ph)
        0: program_regs(1'b0, fttu_pkg::TARGET_RESET, fttu_pkg::FREQ_RESET,
                        fttu_pkg::MAX_DELTA_RESET);
        1: program_regs(1'b1, fttu_pkg::TARGET_RESET, fttu_pkg::FREQ_RESET,
                        fttu_pkg::MAX_DELTA_RESET);
        2: program_regs(1'b1, $urandom_range(1, 4000), $urandom_range(1000, 50000000),
                        $urandom);
        3: program_regs(1'b0, $urandom, 32'd0, 32'hFFFF_FFFF);
        4: program_regs(1'b1, 32'd0, $urandom_range(1, 10000000), $urandom_range(0, 100000));
        5: program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        6: program_regs(1'b0, 32'd1, 32'd1, $urandom_range(0, 1000));
        7: program_regs(1'b1, $urandom_range(1, 32'hFFFF_FFFF), $urandom, $urandom);
        default: program_regs(1'b1, 32'hFFFF_FFFF, 32'($urandom_range(0, 1)), 32'hFFFF_FFFF);
      endcase
      random_beats((ph == 8) ? FLOOD_BEATS : PHASE_BEATS, ph == 8);
    end

    drain_frames();
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
